>>> design/heater_temperature_alert_monitor_macros.svh
// assertion macros for the heater temperature alert monitor
`ifndef HEATER_TEMPERATURE_ALERT_MONITOR_MACROS_SVH
`define HEATER_TEMPERATURE_ALERT_MONITOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define HTAM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htam check failed");

// next-cycle implication, checked out of reset
`define HTAM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htam check failed");

`endif

>>> design/htam_pkg.sv
// shared types and constants for the heater temperature alert monitor
package htam_pkg;

    localparam int TEMP_W  = 11;
    localparam int SP_W    = 9;
    localparam int WIN_W   = 5;
    localparam int HYST_W  = 5;
    localparam int RISE_W  = 6;
    localparam int FREQ_W  = 11;
    localparam int DUR_W   = 13;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;
    localparam int CMP_W   = 12;

    typedef enum logic [1:0] {
        ALERT_NONE     = 2'd0,
        ALERT_FAULT    = 2'd1,
        ALERT_SETPOINT = 2'd2,
        ALERT_HOT_OFF  = 2'd3
    } alert_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_SETPOINT  = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_HYSTERESIS = 2'd2,
        REG_SAFE_RISE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic               mute;
        alert_t             code;
        logic [DUR_W-1:0]   duration;
        logic [FREQ_W-1:0]  frequency;
    } result_t;

    localparam logic [FREQ_W-1:0] FREQ_FAULT    = 11'd800;
    localparam logic [FREQ_W-1:0] FREQ_SETPOINT = 11'd1000;
    localparam logic [FREQ_W-1:0] FREQ_HOT_OFF  = 11'd1500;
    localparam logic [DUR_W-1:0]  DUR_FAULT     = 13'd2000;
    localparam logic [DUR_W-1:0]  DUR_SETPOINT  = 13'd400;
    localparam logic [DUR_W-1:0]  DUR_HOT_OFF   = 13'd5000;

    localparam logic [SP_W-1:0]   SETPOINT_RST  = 9'd50;
    localparam logic [WIN_W-1:0]  WINDOW_RST    = 5'd3;
    localparam logic [HYST_W-1:0] HYST_RST      = 5'd2;
    localparam logic [RISE_W-1:0] RISE_RST      = 6'd10;
    localparam logic signed [TEMP_W-1:0] REF_TEMP_RST = 11'sd1023;

endpackage

>>> design/heater_temperature_alert_monitor.sv
// heater temperature alert monitor: one alert word per temperature sample
//
// input stream s_axis: tdata carries the signed temperature, tuser the
// sensor fault, ten second tick, heater on and calibrating flags.
// output stream m_axis: tdata carries beep frequency and duration, tuser
// the alert code and the override mute flag; exactly one word per sample.
// cfg_wen/cfg_index/cfg_data write setpoint, window, hysteresis and safe
// rise; write only while no sample is in flight.
// latency: the alert for a sample is presented on m_axis the cycle after
// its acceptance when the result register is free, later when it waits.
// throughput: one sample per cycle while the skid register is empty, set by the
// single compare-and-update of the window flag and reference temperature.
// a two-word output buffer (result register plus skid register) lets the
// block keep taking samples while a result waits; s_axis_tready drops only
// when both hold words the receiver has not taken.
// reset clears the buffers, restores the register defaults, clears the
// window flag and sets the reference temperature to its maximum.
module heater_temperature_alert_monitor
    import htam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // temperature
    input  logic [3:0]        s_axis_tuser,   // sensor_fault, ten_second_tick, heater_on, calibrating
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // beep_frequency, beep_duration
    output logic [2:0]        m_axis_tuser,   // alert_code, override_mute
    input  logic              cfg_wen,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [SP_W-1:0]   setpoint_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [HYST_W-1:0] hyst_reg;
    logic [RISE_W-1:0] rise_reg;

    logic                     inside_reg, inside_next;
    logic signed [TEMP_W-1:0] ref_temp_reg, ref_temp_next;

    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic                     accept, out_load;
    logic signed [TEMP_W-1:0] temp_in;
    logic                     fault, tick, heater, calib;
    logic signed [CMP_W-1:0]  temp_x, sp_x, half_w, lo_lim, hi_lim, trip_lim;
    logic                     in_win;

    assign temp_in = s_axis_tdata[TEMP_W-1:0];
    assign fault   = s_axis_tuser[0];
    assign tick    = s_axis_tuser[1];
    assign heater  = s_axis_tuser[2];
    assign calib   = s_axis_tuser[3];

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = !out_valid_reg || m_axis_tready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= SETPOINT_RST;
            window_reg   <= WINDOW_RST;
            hyst_reg     <= HYST_RST;
            rise_reg     <= RISE_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SETPOINT:   setpoint_reg <= cfg_data[SP_W-1:0];
                REG_WINDOW:     window_reg   <= cfg_data[WIN_W-1:0];
                REG_HYSTERESIS: hyst_reg     <= cfg_data[HYST_W-1:0];
                REG_SAFE_RISE:  rise_reg     <= cfg_data[RISE_W-1:0];
                default:        ;
            endcase
        end
    end

    // window and reference compare
    always_comb
    begin
        temp_x   = CMP_W'(temp_in);
        sp_x     = signed'({{(CMP_W-SP_W){1'b0}}, setpoint_reg});
        half_w   = signed'({{(CMP_W-WIN_W){1'b0}}, window_reg})
                 + (inside_reg ? signed'({{(CMP_W-HYST_W){1'b0}}, hyst_reg})
                               : {CMP_W{1'b0}});
        lo_lim   = sp_x - half_w;
        hi_lim   = sp_x + half_w;
        trip_lim = CMP_W'(ref_temp_reg) + signed'({{(CMP_W-RISE_W){1'b0}}, rise_reg});
        in_win   = (temp_x > lo_lim) && (temp_x < hi_lim);

        res_next      = '0;
        inside_next   = inside_reg;
        ref_temp_next = ref_temp_reg;

        if (fault)
        begin
            if (tick)
            begin
                res_next.code      = ALERT_FAULT;
                res_next.frequency = FREQ_FAULT;
                res_next.duration  = DUR_FAULT;
                res_next.mute      = 1'b1;
            end
        end
        else
        begin
            inside_next = in_win;
            if (in_win && (!inside_reg || hyst_reg == '0) && heater)
            begin
                res_next.code      = ALERT_SETPOINT;
                res_next.frequency = FREQ_SETPOINT;
                res_next.duration  = DUR_SETPOINT;
                res_next.mute      = 1'b0;
            end
            if (heater || calib)
            begin
                ref_temp_next = temp_in;
            end
            else if (tick)
            begin
                if (temp_in < ref_temp_reg)
                begin
                    ref_temp_next = temp_in;
                end
                else if (temp_x >= trip_lim)
                begin
                    res_next.code      = ALERT_HOT_OFF;
                    res_next.frequency = FREQ_HOT_OFF;
                    res_next.duration  = DUR_HOT_OFF;
                    res_next.mute      = 1'b1;
                end
            end
        end
    end

    // monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg   <= 1'b0;
            ref_temp_reg <= REF_TEMP_RST;
        end
        else if (accept)
        begin
            inside_reg   <= inside_next;
            ref_temp_reg <= ref_temp_next;
        end
    end

    // result register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_load)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_load)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.duration, out_reg.frequency};
    assign m_axis_tuser  = {out_reg.mute, out_reg.code};

    `include "heater_temperature_alert_monitor_macros.svh"

    `HTAM_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `HTAM_ASSERT_NOW(a_quiet_when_none,
        out_valid_reg && out_reg.code == ALERT_NONE,
        out_reg.frequency == '0 && out_reg.duration == '0 && !out_reg.mute)
    `HTAM_ASSERT_NXT(a_fault_holds_state, accept && fault,
        $stable(ref_temp_reg) && $stable(inside_reg))
    `HTAM_ASSERT_NXT(a_heater_tracks_ref, accept && !fault && heater,
        ref_temp_reg == $past(temp_in))

endmodule

>>> verif/heater_temperature_alert_monitor_checker.sv
// checker for the heater temperature alert monitor: tracks config, predicts and compares alerts
module heater_temperature_alert_monitor_checker
    import htam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // temperature
    input  logic [3:0]        s_axis_tuser,   // sensor_fault, ten_second_tick, heater_on, calibrating
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [23:0]       m_axis_tdata,   // beep_frequency, beep_duration
    input  logic [2:0]        m_axis_tuser,   // alert_code, override_mute
    input  logic              cfg_wen,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int unsigned       fail_count,
    output int unsigned       pending,
    output int unsigned       words_checked,
    output int unsigned       fault_alerts,
    output int unsigned       setpoint_alerts,
    output int unsigned       hot_off_alerts
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        alert_t             code;
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
        logic               mute;
    } alert_word_t;

    alert_word_t expected_alerts[$];

    logic [SP_W-1:0]   setpoint;
    logic [WIN_W-1:0]  window;
    logic [HYST_W-1:0] hyst;
    logic [RISE_W-1:0] rise;
    logic              in_window;
    int                ref_temp;

    function automatic alert_word_t beep_for(input alert_t code);
        case (code)
            ALERT_FAULT:    return '{ALERT_FAULT, FREQ_FAULT, DUR_FAULT, 1'b1};
            ALERT_SETPOINT: return '{ALERT_SETPOINT, FREQ_SETPOINT, DUR_SETPOINT, 1'b0};
            ALERT_HOT_OFF:  return '{ALERT_HOT_OFF, FREQ_HOT_OFF, DUR_HOT_OFF, 1'b1};
            default:        return '{ALERT_NONE, '0, '0, 1'b0};
        endcase
    endfunction

    function automatic alert_word_t predict_alert(input logic signed [TEMP_W-1:0] temp,
                                                  input logic fault, input logic tick,
                                                  input logic heater, input logic calib);
        alert_word_t word;
        int t, sp, half;
        word = beep_for(ALERT_NONE);
        t = temp;
        sp = setpoint;
        // a faulty sensor leaves window flag and reference alone
        if (fault)
            return tick ? beep_for(ALERT_FAULT) : word;
        half = int'(window) + (in_window ? int'(hyst) : 0);
        if (t > sp - half && t < sp + half)
        begin
            if ((!in_window || hyst == 0) && heater)
                word = beep_for(ALERT_SETPOINT);
            in_window = 1'b1;
        end
        else
        begin
            in_window = 1'b0;
        end
        if (heater || calib)
        begin
            ref_temp = t;
        end
        else if (tick)
        begin
            if (t < ref_temp)
                ref_temp = t;
            else if (t >= ref_temp + int'(rise))
                word = beep_for(ALERT_HOT_OFF);
        end
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alert_word_t want, got;
        if (!rst_n)
        begin
            setpoint        = SETPOINT_RST;
            window          = WINDOW_RST;
            hyst            = HYST_RST;
            rise            = RISE_RST;
            in_window       = 1'b0;
            ref_temp        = REF_TEMP_RST;
            expected_alerts.delete();
            fail_count      = 0;
            words_checked   = 0;
            fault_alerts    = 0;
            setpoint_alerts = 0;
            hot_off_alerts  = 0;
            pending        <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_SETPOINT:   setpoint = cfg_data[SP_W-1:0];
                    REG_WINDOW:     window   = cfg_data[WIN_W-1:0];
                    REG_HYSTERESIS: hyst     = cfg_data[HYST_W-1:0];
                    REG_SAFE_RISE:  rise     = cfg_data[RISE_W-1:0];
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_alerts.push_back(predict_alert(s_axis_tdata[TEMP_W-1:0],
                    s_axis_tuser[0], s_axis_tuser[1], s_axis_tuser[2], s_axis_tuser[3]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{alert_t'(m_axis_tuser[1:0]), m_axis_tdata[FREQ_W-1:0],
                        m_axis_tdata[FREQ_W +: DUR_W], m_axis_tuser[2]};
                words_checked++;
                if (expected_alerts.size() == 0)
                begin
                    fail_count++;
                    $error("alert word with none expected: code %0d", got.code);
                end
                else
                begin
                    want = expected_alerts.pop_front();
                    case (want.code)
                        ALERT_FAULT:    fault_alerts++;
                        ALERT_SETPOINT: setpoint_alerts++;
                        ALERT_HOT_OFF:  hot_off_alerts++;
                        default:        ;
                    endcase
                    if (got.code !== want.code)
                    begin
                        fail_count++;
                        $error("alert_code expected %0d got %0d", want.code, got.code);
                    end
                    if (got.freq !== want.freq)
                    begin
                        fail_count++;
                        $error("beep_frequency expected %0d got %0d", want.freq, got.freq);
                    end
                    if (got.dur !== want.dur)
                    begin
                        fail_count++;
                        $error("beep_duration expected %0d got %0d", want.dur, got.dur);
                    end
                    if (got.mute !== want.mute)
                    begin
                        fail_count++;
                        $error("override_mute expected %0d got %0d", want.mute, got.mute);
                    end
                end
            end
            pending <= expected_alerts.size();
        end
    end

endmodule

>>> verif/heater_temperature_alert_monitor_test.sv
// testbench top for the heater temperature alert monitor: stimulus, stalls and verdict
module heater_temperature_alert_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;
    import htam_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_CYCLES     = 80;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;
    logic [3:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              cfg_wen = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    int unsigned fail_count, pending, words_checked;
    int unsigned fault_alerts, setpoint_alerts, hot_off_alerts;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;
    int          settings_used = 0;

    // generator's own copy of the setup, for aiming temperatures
    int sp_now = 50;
    int win_now = 3;
    int hyst_now = 2;
    int last_temp = 0;

    heater_temperature_alert_monitor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    heater_temperature_alert_monitor_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .words_checked   (words_checked),
        .fault_alerts    (fault_alerts),
        .setpoint_alerts (setpoint_alerts),
        .hot_off_alerts  (hot_off_alerts)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_sample(input int temp, input logic fault, input logic tick,
                               input logic heater, input logic calib);
        logic signed [TEMP_W-1:0] t;
        t = TEMP_W'(temp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16 - TEMP_W){1'b0}}, t};
        s_axis_tuser  <= {calib, heater, tick, fault};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // drain, then write all four registers back to back
    task automatic configure(input int sp, input int win, input int hy, input int rs);
        cfg_idx_t         order[4];
        logic [CFG_W-1:0] vals[4];
        order = '{REG_SETPOINT, REG_WINDOW, REG_HYSTERESIS, REG_SAFE_RISE};
        vals  = '{CFG_W'(sp), CFG_W'(win), CFG_W'(hy), CFG_W'(rs)};
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
        for (int k = 0; k < 4; k++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_wen  <= 1'b0;
        sp_now   = sp;
        win_now  = win;
        hyst_now = hy;
        settings_used++;
    endtask

    task automatic random_setup();
        configure($urandom_range(300), $urandom_range(31, 1),
                  ($urandom_range(99) < 20) ? 0 : $urandom_range(31), $urandom_range(63, 1));
    endtask

    task automatic random_sample();
        int sel, span, v;
        sel  = $urandom_range(99);
        span = win_now + hyst_now + 4;
        if (sel < 50)
            v = sp_now + int'($urandom_range(2 * span)) - span;
        else if (sel < 80)
            v = last_temp + int'($urandom_range(24)) - 12;
        else
            v = int'($urandom_range(2047)) - 1024;
        if (v > 1023)
            v = 1023;
        if (v < -1024)
            v = -1024;
        last_temp = v;
        send_sample(v, $urandom_range(99) < 8, $urandom_range(99) < 40,
                    $urandom_range(99) < 45, $urandom_range(99) < 15);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: window entry, hysteresis, faults, reference tracking
        send_sample(50, 0, 0, 1, 0);
        send_sample(52, 0, 0, 1, 0);
        send_sample(54, 0, 0, 1, 0);
        send_sample(56, 0, 0, 1, 0);
        send_sample(1023, 1, 1, 0, 0);
        send_sample(-1024, 1, 0, 0, 0);
        send_sample(-1024, 0, 1, 0, 0);
        send_sample(-1014, 0, 1, 0, 0);
        send_sample(-1015, 0, 0, 0, 0);
        send_sample(1023, 0, 1, 0, 1);
        send_sample(1023, 0, 1, 0, 0);
        send_sample(-1024, 0, 0, 1, 1);

        // widest setup
        configure(300, 31, 31, 63);
        send_sample(300, 0, 0, 1, 0);
        send_sample(330, 0, 1, 1, 0);
        send_sample(-1024, 0, 1, 0, 0);
        send_sample(-961, 0, 1, 0, 0);

        // zero window and zero safe rise
        configure(0, 0, 0, 0);
        send_sample(0, 0, 0, 1, 0);
        send_sample(5, 0, 1, 0, 0);
        send_sample(5, 0, 1, 0, 0);

        // zero hysteresis repeats the setpoint beep
        configure(100, 1, 0, 1);
        send_sample(100, 0, 0, 1, 0);
        send_sample(100, 0, 0, 1, 0);
        send_sample(101, 0, 0, 1, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 63 : 0;
            rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 10 : 0;
            random_setup();
            if (ph == 2)
                hold_req <= 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i == ITEMS_PER_PHASE / 2)
                    random_setup();
                random_sample();
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);

        $display("checked %0d alert words: %0d sensor fault, %0d setpoint, %0d heating while off",
                 words_checked, fault_alerts, setpoint_alerts, hot_off_alerts);
        $display("ran %0d register setups under three stall patterns and one long output hold",
                 settings_used + 1);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> heater_temperature_alert_monitor.f
+incdir+design
design/htam_pkg.sv
design/heater_temperature_alert_monitor.sv
verif/heater_temperature_alert_monitor_checker.sv
verif/heater_temperature_alert_monitor_test.sv
